// ===== design/depq_pkg.sv =====
// Shared types, sizes and helpers for the double-ended priority queue.
`default_nettype none
package depq_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 64;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic [CNT_W-1:0]              t_count;

    typedef enum logic [2:0] {
        REQ_INSERT  = 3'd0,
        REQ_SIZE    = 3'd1,
        REQ_CLEAR   = 3'd2,
        REQ_GET_MIN = 3'd3,
        REQ_GET_MAX = 3'd4,
        REQ_POP_MIN = 3'd5,
        REQ_POP_MAX = 3'd6
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_VALUE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_SHIFT  = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_value   value;
    } t_cell_ctrl;

    function automatic logic signed [63:0] sext_value(input t_value v);
        sext_value = 64'(v);
    endfunction

endpackage
`default_nettype wire

// ===== design/double_ended_priority_queue.sv =====
// Top level: sorted cell chain with request decode and registered result.
// A transferred request is registered and executes while busy is high; its result and strobe are registered.
// A new request is taken only while busy is low; busy stays high for the execute cycle.
// Insert shifts the cells above its slot, a pop of the minimum shifts the whole chain.
// The receiver cannot stall: each result is shown for one cycle only.
// Synchronous active-low reset empties the store; cell contents stay undefined.
`default_nettype none
module double_ended_priority_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     start,
    output logic                    busy,
    input  wire  [2:0]              i_req_type,
    input  wire  signed [63:0]      i_value,
    output logic                    o_valid,
    output logic [1:0]              o_status,
    output logic signed [63:0]      o_result_value,
    output logic [6:0]              o_count
);

    localparam int N = depq_pkg::CAPACITY;

    logic                     r_busy;
    logic [2:0]               r_req;
    depq_pkg::t_value         r_value;
    depq_pkg::t_count         r_count;
    depq_pkg::t_count         n_count;
    logic                     r_valid;
    depq_pkg::t_status        r_status;
    logic signed [63:0]       r_result;

    depq_pkg::t_cell_ctrl     cell_ctrl;
    depq_pkg::t_value         cell_e [N];
    logic                     cell_p [N];
    logic                     cell_occ [N];
    depq_pkg::t_value         max_val;
    depq_pkg::t_status        n_status;
    logic signed [63:0]       n_result;
    depq_pkg::t_cell_op       n_op;

    assign busy = r_busy;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            depq_pkg::t_value prev_e;
            logic             prev_p;
            depq_pkg::t_value next_e;

            assign cell_occ[g] = (r_count > depq_pkg::CNT_W'(g));
            if (g == 0) begin : g_first
                assign prev_e = '0;
                assign prev_p = 1'b0;
            end else begin : g_mid
                assign prev_e = cell_e[g-1];
                assign prev_p = cell_p[g-1];
            end
            if (g == N - 1) begin : g_last
                assign next_e = '0;
            end else begin : g_inner
                assign next_e = cell_e[g+1];
            end

            depq_cell u_cell (
                .i_clk    (i_clk),
                .i_ctrl   (cell_ctrl),
                .i_occ    (cell_occ[g]),
                .i_prev_e (prev_e),
                .i_prev_p (prev_p),
                .i_next_e (next_e),
                .o_e      (cell_e[g]),
                .o_p      (cell_p[g])
            );
        end
    endgenerate

    // Top of the store: select the cell just below the fill count.
    always_comb begin
        max_val = '0;
        for (int i = 0; i < N; i++) begin
            if (r_count == depq_pkg::CNT_W'(i + 1)) begin
                max_val = max_val | cell_e[i];
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = depq_pkg::ST_OK;
        n_result = '0;
        n_op     = depq_pkg::CELL_HOLD;
        unique case (r_req)
            depq_pkg::REQ_INSERT: begin
                if (r_count == depq_pkg::CNT_W'(N)) begin
                    n_status = depq_pkg::ST_FULL;
                end else begin
                    n_op    = depq_pkg::CELL_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            depq_pkg::REQ_CLEAR: n_count = '0;
            depq_pkg::REQ_GET_MIN, depq_pkg::REQ_GET_MAX,
            depq_pkg::REQ_POP_MIN, depq_pkg::REQ_POP_MAX: begin
                if (r_count == '0) begin
                    n_status = depq_pkg::ST_EMPTY;
                end else begin
                    n_status = depq_pkg::ST_VALUE;
                    if (r_req == depq_pkg::REQ_GET_MIN ||
                        r_req == depq_pkg::REQ_POP_MIN) begin
                        n_result = depq_pkg::sext_value(cell_e[0]);
                    end else begin
                        n_result = depq_pkg::sext_value(max_val);
                    end
                    if (r_req == depq_pkg::REQ_POP_MIN) begin
                        n_op = depq_pkg::CELL_SHIFT;
                    end
                    if (r_req == depq_pkg::REQ_POP_MIN ||
                        r_req == depq_pkg::REQ_POP_MAX) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Cells move only in the execute cycle.
    always_comb begin
        cell_ctrl.value = r_value;
        cell_ctrl.op    = r_busy ? n_op : depq_pkg::CELL_HOLD;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_valid <= r_busy;
            if (r_busy) begin
                r_busy  <= 1'b0;
                r_count <= n_count;
            end else if (start) begin
                r_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && start) begin
            r_req   <= i_req_type;
            r_value <= i_value[depq_pkg::VALUE_WIDTH-1:0];
        end
        if (r_busy) begin
            r_status <= n_status;
            r_result <= n_result;
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_result_value = r_result;
    assign o_count        = 7'(r_count);

endmodule
`default_nettype wire

// ===== design/depq_cell.sv =====
// One slot of the sorted cell chain: holds a value and trades it with its neighbors.
`default_nettype none
module depq_cell (
    input  wire                    i_clk,
    input  depq_pkg::t_cell_ctrl   i_ctrl,
    input  wire                    i_occ,
    input  depq_pkg::t_value       i_prev_e,
    input  wire                    i_prev_p,
    input  depq_pkg::t_value       i_next_e,
    output depq_pkg::t_value       o_e,
    output logic                   o_p
);

    depq_pkg::t_value r_e;
    depq_pkg::t_value n_e;

    // Set at or after the insert position; empty slots always qualify.
    assign o_p = i_occ ? ($signed(i_ctrl.value) < r_e) : 1'b1;
    assign o_e = r_e;

    always_comb begin
        unique case (i_ctrl.op)
            depq_pkg::CELL_INSERT: begin
                if (i_prev_p) begin
                    n_e = i_prev_e;
                end else if (o_p) begin
                    n_e = i_ctrl.value;
                end else begin
                    n_e = r_e;
                end
            end
            depq_pkg::CELL_SHIFT: n_e = i_next_e;
            default:              n_e = r_e;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_e <= n_e;
    end

endmodule
`default_nettype wire

// ===== design/depq_checker.sv =====
// Port-level checks for the double-ended priority queue, bound to the top level.
`default_nettype none
module depq_checker (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    input  wire                busy,
    input  wire                o_valid,
    input  wire  [1:0]         o_status,
    input  wire  signed [63:0] o_result_value,
    input  wire  [6:0]         o_count
);

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request transfer");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("result strobe missing two cycles after transfer");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe repeated");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_count <= 7'(depq_pkg::CAPACITY)))
        else $error("count above capacity");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == depq_pkg::ST_EMPTY) |-> (o_result_value == '0 && o_count == '0))
        else $error("empty error with nonzero value or count");

endmodule

bind double_ended_priority_queue depq_checker u_depq_checker (.*);
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the double-ended priority queue: request driver and result tracker.
`timescale 1ns / 100ps
module testbench;

    localparam logic [2:0] REQ_NOP        = 3'd7;
    localparam int         CLK_HALF       = 10;
    localparam int         RESET_CYCLES   = 10;
    localparam int         SETTLE_CYCLES  = 4;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         PHASE_ITEMS    = 225;
    localparam int         OVERFLOW_FILL  = depq_pkg::CAPACITY + 6;

    typedef enum int {
        MIX_BALANCED,
        MIX_FILL,
        MIX_DRAIN
    } t_mix;

    typedef struct {
        depq_pkg::t_status    status;
        logic signed [63:0]   value;
        logic [6:0]           count;
    } t_outcome;

    // Sorted model of the store plus the outcomes still owed by the block.
    class queue_tracker;
        depq_pkg::t_value sorted_store[$];
        t_outcome         owed_outcomes[$];
        int               mismatches;
        int               results_checked;
        int               full_drops;
        int               empty_errors;
        int               peak_count;

        function int pending();
            return owed_outcomes.size();
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        function void note_request(logic [2:0] req, depq_pkg::t_value v);
            t_outcome o;
            int       pos;
            o.status = depq_pkg::ST_OK;
            o.value  = '0;
            case (req)
                depq_pkg::REQ_INSERT: begin
                    if (sorted_store.size() >= depq_pkg::CAPACITY) begin
                        o.status = depq_pkg::ST_FULL;
                    end else begin
                        // keep equal values in arrival order, new copy after old ones
                        pos = sorted_store.size();
                        while (pos > 0 && v < sorted_store[pos-1]) pos--;
                        sorted_store.insert(pos, v);
                    end
                end
                depq_pkg::REQ_CLEAR: sorted_store.delete();
                depq_pkg::REQ_GET_MIN, depq_pkg::REQ_GET_MAX,
                depq_pkg::REQ_POP_MIN, depq_pkg::REQ_POP_MAX: begin
                    if (sorted_store.size() == 0) begin
                        o.status = depq_pkg::ST_EMPTY;
                    end else begin
                        o.status = depq_pkg::ST_VALUE;
                        if (req == depq_pkg::REQ_GET_MIN || req == depq_pkg::REQ_POP_MIN)
                            o.value = sorted_store[0];
                        else
                            o.value = sorted_store[$];
                        if (req == depq_pkg::REQ_POP_MIN)
                            void'(sorted_store.pop_front());
                        else if (req == depq_pkg::REQ_POP_MAX)
                            void'(sorted_store.pop_back());
                    end
                end
                default: ;
            endcase
            o.count = 7'(sorted_store.size());
            if (sorted_store.size() > peak_count) peak_count = sorted_store.size();
            owed_outcomes.push_back(o);
        endfunction

        task check_result(logic [1:0] st, logic signed [63:0] val, logic [6:0] cnt);
            t_outcome o;
            if (owed_outcomes.size() == 0) begin
                report_mismatch("result strobe with no request outstanding");
            end else begin
                o = owed_outcomes.pop_front();
                results_checked++;
                if (o.status == depq_pkg::ST_FULL) full_drops++;
                if (o.status == depq_pkg::ST_EMPTY) empty_errors++;
                if (st !== o.status)
                    report_mismatch($sformatf("status %0d, expected %0d", st, o.status));
                if (val !== o.value)
                    report_mismatch($sformatf("result_value %0d, expected %0d", val, o.value));
                if (cnt !== o.count)
                    report_mismatch($sformatf("count %0d, expected %0d", cnt, o.count));
            end
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [2:0]          i_req_type;
    logic signed [63:0]  i_value;
    logic                o_valid;
    logic [1:0]          o_status;
    logic signed [63:0]  o_result_value;
    logic [6:0]          o_count;

    queue_tracker tracker;
    int           idle_pct;
    int           items_sent;
    int           idle_cycles;

    double_ended_priority_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_count        (o_count)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Note each request transfer and check each result at the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) tracker.check_result(o_status, o_result_value, o_count);
            if (start && !busy) tracker.note_request(i_req_type, i_value);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("double_ended_priority_queue test failed");
                $finish;
            end
        end
    end

    // Hold the request until it transfers, then idle at random.
    task send_request(logic [2:0] req, depq_pkg::t_value v);
        start      <= 1'b1;
        i_req_type <= req;
        i_value    <= v;
        do @(posedge i_clk); while (busy);
        items_sent++;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task wait_all_results();
        start <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic depq_pkg::t_value rand_value();
        int pick;
        pick = $urandom_range(9);
        case (pick)
            0:       return {1'b0, {63{1'b1}}};
            1:       return {1'b1, {63{1'b0}}};
            2, 3, 4: return depq_pkg::t_value'($signed($urandom_range(8)) - 4);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [2:0] rand_req(t_mix mix);
        int r;
        r = $urandom_range(99);
        case (mix)
            MIX_FILL: begin
                if (r < 85) return depq_pkg::REQ_INSERT;
                if (r < 88) return depq_pkg::REQ_SIZE;
                if (r < 91) return depq_pkg::REQ_GET_MIN;
                if (r < 94) return depq_pkg::REQ_GET_MAX;
                if (r < 97) return depq_pkg::REQ_POP_MIN;
                return depq_pkg::REQ_POP_MAX;
            end
            MIX_DRAIN: begin
                if (r < 20) return depq_pkg::REQ_INSERT;
                if (r < 24) return depq_pkg::REQ_SIZE;
                if (r < 30) return depq_pkg::REQ_GET_MIN;
                if (r < 36) return depq_pkg::REQ_GET_MAX;
                if (r < 67) return depq_pkg::REQ_POP_MIN;
                return depq_pkg::REQ_POP_MAX;
            end
            default: begin
                if (r < 45) return depq_pkg::REQ_INSERT;
                if (r < 52) return depq_pkg::REQ_SIZE;
                if (r < 54) return depq_pkg::REQ_CLEAR;
                if (r < 62) return depq_pkg::REQ_GET_MIN;
                if (r < 70) return depq_pkg::REQ_GET_MAX;
                if (r < 85) return depq_pkg::REQ_POP_MIN;
                if (r < 99) return depq_pkg::REQ_POP_MAX;
                return REQ_NOP;
            end
        endcase
    endfunction

    // Overflow the store once, then run fill, drain and balanced stretches in random order.
    task run_phase(int pct);
        int   phase_end;
        int   seg_len;
        t_mix mix;
        idle_pct  = pct;
        phase_end = items_sent + PHASE_ITEMS;
        send_request(depq_pkg::REQ_CLEAR, rand_value());
        repeat (OVERFLOW_FILL) send_request(depq_pkg::REQ_INSERT, rand_value());
        while (items_sent < phase_end) begin
            mix     = t_mix'($urandom_range(2));
            seg_len = $urandom_range(15, 50);
            repeat (seg_len) send_request(rand_req(mix), rand_value());
        end
    endtask

    initial begin
        tracker    = new();
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req_type = depq_pkg::REQ_INSERT;
        i_value    = '0;
        idle_pct   = 0;
        items_sent = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes, duplicates, every request kind, empty store and unused code.
        send_request(depq_pkg::REQ_INSERT, 64'sd0);
        send_request(depq_pkg::REQ_INSERT, {1'b0, {63{1'b1}}});
        send_request(depq_pkg::REQ_INSERT, {1'b1, {63{1'b0}}});
        send_request(depq_pkg::REQ_INSERT, -64'sd1);
        send_request(depq_pkg::REQ_INSERT, 64'sd1);
        send_request(depq_pkg::REQ_GET_MIN, '1);
        send_request(depq_pkg::REQ_GET_MAX, '0);
        send_request(depq_pkg::REQ_SIZE, '1);
        send_request(depq_pkg::REQ_INSERT, {1'b0, {63{1'b1}}});
        send_request(depq_pkg::REQ_POP_MAX, '0);
        send_request(depq_pkg::REQ_POP_MAX, '0);
        send_request(depq_pkg::REQ_POP_MIN, '1);
        send_request(depq_pkg::REQ_POP_MIN, '0);
        send_request(depq_pkg::REQ_SIZE, '0);
        send_request(REQ_NOP, '1);
        send_request(depq_pkg::REQ_CLEAR, '1);
        send_request(depq_pkg::REQ_GET_MIN, '0);
        send_request(depq_pkg::REQ_GET_MAX, '0);
        send_request(depq_pkg::REQ_POP_MIN, '0);
        send_request(depq_pkg::REQ_POP_MAX, '0);
        send_request(depq_pkg::REQ_INSERT, {32{2'b01}});
        send_request(depq_pkg::REQ_INSERT, {32{2'b10}});
        send_request(depq_pkg::REQ_POP_MIN, '0);
        send_request(depq_pkg::REQ_POP_MAX, '0);
        wait_all_results();

        run_phase(0);
        wait_all_results();
        run_phase(79);
        wait_all_results();
        run_phase(34);
        wait_all_results();

        $display("covered %0d requests, %0d results checked, peak occupancy %0d of %0d",
                 items_sent, tracker.results_checked, tracker.peak_count,
                 depq_pkg::CAPACITY);
        $display("full-store drops %0d, empty-store errors %0d, mismatches %0d",
                 tracker.full_drops, tracker.empty_errors, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("double_ended_priority_queue test passed");
        end else begin
            $display("double_ended_priority_queue test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/depq_pkg.sv
design/depq_cell.sv
design/double_ended_priority_queue.sv
design/depq_checker.sv
tb/testbench.sv
